// ----- hw/rtl/plist_pkg.sv -----
package plist_pkg;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_GET    = 2'd2,
    MODE_LOCATE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] word;
    logic [4:0]         found;
    logic [4:0]         length;
    logic               empty;
    logic               full;
  } result_t;

  localparam logic [4:0] MaxLengthReset = 5'd16;

endpackage

// ----- hw/rtl/plist_mem.sv -----
module plist_mem #(
  parameter int Depth = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data
);

  logic [31:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/plist_ctrl.sv -----
module plist_ctrl
  import plist_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int AW       = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [4:0]         position,
  input  logic signed [31:0] value,
  output logic               res_valid,
  input  logic               res_ready,
  output result_t            res,
  output logic               mem_rd_en,
  output logic [AW-1:0]      mem_rd_addr,
  input  logic [31:0]        mem_rd_data,
  output logic               mem_wr_en,
  output logic [AW-1:0]      mem_wr_addr,
  output logic [31:0]        mem_wr_data
);

  // Largest length the 5-bit register can reach under this capacity
  localparam int CapLim = (CAPACITY > 31) ? 31 : CAPACITY;
  localparam logic [4:0] CapMax = 5'(CapLim);

  state_t      state, state_next;
  mode_t       op;
  logic        okq;
  logic [4:0]  pidx;
  logic [31:0] val;
  logic [4:0]  len;
  logic [4:0]  len_next;
  logic [4:0]  cnt;
  logic [4:0]  rd_addr;
  logic        rd_vld;
  logic [4:0]  rd_a;
  logic [31:0] word;
  logic [4:0]  found;
  logic [4:0]  max_length;
  logic [4:0]  cap;

  logic        acc;
  logic        pos_lo;
  logic        ins_ok;
  logic        rd_ok;
  logic        acc_ok;
  logic [4:0]  acc_cnt;
  logic [4:0]  acc_addr;
  logic [4:0]  p_in;

  always_comb begin
    if (max_length == 5'd0) begin
      cap = 5'd1;
    end else if (max_length > CapMax) begin
      cap = CapMax;
    end else begin
      cap = max_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MaxLengthReset;
    end else if (cfg_wr_en) begin
      max_length <= cfg_wr_data;
    end
  end

  // Request check and walk setup at accept time
  assign acc    = in_valid && in_ready;
  assign p_in   = position - 5'd1;
  assign pos_lo = (position != 5'd0);
  assign ins_ok = pos_lo && ({1'b0, position} <= ({1'b0, len} + 6'd1)) && (len < cap);
  assign rd_ok  = pos_lo && (position <= len);

  always_comb begin
    acc_ok   = 1'b0;
    acc_cnt  = 5'd0;
    acc_addr = 5'd0;
    unique case (mode_t'(mode))
      MODE_INSERT: begin
        acc_ok   = ins_ok;
        acc_cnt  = ins_ok ? (len - p_in) : 5'd0;
        acc_addr = len - 5'd1;
      end
      MODE_DELETE: begin
        acc_ok   = rd_ok;
        acc_cnt  = rd_ok ? (len - p_in) : 5'd0;
        acc_addr = p_in;
      end
      MODE_GET: begin
        acc_ok   = rd_ok;
        acc_cnt  = rd_ok ? 5'd1 : 5'd0;
        acc_addr = p_in;
      end
      default: begin
        acc_ok   = 1'b1;
        acc_cnt  = len;
        acc_addr = 5'd0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_RUN;
      S_RUN:  if (cnt == 5'd0) state_next = S_FIN;
      S_FIN:  if (res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    len_next = len;
    if (okq && op == MODE_INSERT) begin
      len_next = len + 5'd1;
    end else if (okq && op == MODE_DELETE) begin
      len_next = len - 5'd1;
    end
  end

  always_comb begin
    in_ready    = (state == S_IDLE);
    mem_rd_en   = (state == S_RUN) && (cnt != 5'd0);
    mem_rd_addr = AW'(rd_addr);
    mem_wr_en   = 1'b0;
    mem_wr_addr = AW'(pidx);
    mem_wr_data = val;
    res_valid   = (state == S_FIN);
    unique case (state)
      S_RUN: begin
        // insert moves each word up one slot, delete moves it down
        if (rd_vld && op == MODE_INSERT) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = AW'(rd_a + 5'd1);
          mem_wr_data = mem_rd_data;
        end else if (rd_vld && op == MODE_DELETE && rd_a != pidx) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = AW'(rd_a - 5'd1);
          mem_wr_data = mem_rd_data;
        end
      end
      S_FIN: begin
        mem_wr_en = okq && (op == MODE_INSERT);
      end
      default: begin
        mem_wr_en = 1'b0;
      end
    endcase
    res.ok     = okq;
    res.word   = word;
    res.found  = found;
    res.length = len_next;
    res.empty  = (len_next == 5'd0);
    res.full   = (len_next >= cap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      len    <= 5'd0;
      cnt    <= 5'd0;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= mem_rd_en;
      if (acc) begin
        cnt <= acc_cnt;
      end else if (state == S_RUN && rd_vld && op == MODE_LOCATE && found == 5'd0 &&
                   mem_rd_data == val) begin
        cnt <= 5'd0;
      end else if (mem_rd_en) begin
        cnt <= cnt - 5'd1;
      end
      if (state == S_FIN && res_ready) begin
        len <= len_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_a <= rd_addr;
    if (acc) begin
      op      <= mode_t'(mode);
      okq     <= acc_ok;
      pidx    <= p_in;
      val     <= value;
      rd_addr <= acc_addr;
      word    <= 32'd0;
      found   <= 5'd0;
    end else begin
      if (mem_rd_en) begin
        rd_addr <= (op == MODE_INSERT) ? (rd_addr - 5'd1) : (rd_addr + 5'd1);
      end
      if (state == S_RUN && rd_vld) begin
        case (op) inside
          MODE_DELETE, MODE_GET: begin
            if (rd_a == pidx) word <= mem_rd_data;
          end
          MODE_LOCATE: begin
            // later reads still in flight are ignored once a match is held
            if (found == 5'd0 && mem_rd_data == val) found <= rd_a + 5'd1;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ----- hw/rtl/positional_list_engine_core.sv -----
// The walk visits n entries of the list memory for each accepted item:
// len - pos + 1 for insert and delete, 1 for get, up to len for locate, 0 on failure.
// The next item is taken only once the previous result has moved to the output register.
// One item is in flight at a time; the walk does one read of the list memory per cycle.
// A finished result sits in an output register, so the next item is taken meanwhile.
// Synchronous reset empties the list and sets max_length to 16; memory is not cleared.
module positional_list_engine_core
  import plist_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [4:0]         position,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               ok,
  output logic signed [31:0] word_out,
  output logic [4:0]         found_position,
  output logic [4:0]         length_now,
  output logic               is_empty,
  output logic               is_full
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic          res_valid;
  logic          res_ready;
  result_t       res;
  result_t       res_q;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [31:0]   mem_rd_data;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [31:0]   mem_wr_data;

  plist_ctrl #(
    .CAPACITY(CAPACITY),
    .AW      (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .position   (position),
    .value      (value),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_rd_en  (mem_rd_en),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data)
  );

  plist_mem #(
    .Depth(CAPACITY),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_q <= res;
    end
  end

  assign ok             = res_q.ok;
  assign word_out       = res_q.word;
  assign found_position = res_q.found;
  assign length_now     = res_q.length;
  assign is_empty       = res_q.empty;
  assign is_full        = res_q.full;

  a_fail_no_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> word_out == 32'd0)
    else $error("failed request returned a word");

  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> is_empty == (length_now == 5'd0))
    else $error("empty flag disagrees with length");

  a_found_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && found_position != 5'd0 |-> found_position <= length_now)
    else $error("found position beyond list length");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while walk in progress");

endmodule
